// ===== sv/ptpag_pkg.sv =====
package ptpag_pkg;

	localparam int ADC_BITS_DEF = 10;   // default sample width
	localparam int LEVEL_GAIN   = 5;
	localparam int FULL_SCALE   = 255;
	localparam int BRIGHT_W     = 8;    // brightness field width
	localparam int LEVEL_FW     = 13;   // level field width on the output
	localparam int OUT_DATA_W   = 24;   // brightness + level, padded to bytes
	localparam int Q_DEPTH      = 2;    // window results between front and back

endpackage

// ===== sv/ptpag_front.sv =====
module ptpag_front #(
	parameter int ADC_BITS = ptpag_pkg::ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADC_BITS-1:0] in_sample,
	input  logic                in_last,
	input  logic                q_full,
	output logic                q_push,
	output logic [ADC_BITS+2:0] q_level,
	output logic [ADC_BITS+2:0] q_peak
);
	import ptpag_pkg::*;

	localparam int LEVEL_W = ADC_BITS + 3;
	localparam logic [ADC_BITS:0] MIN_EMPTY = (ADC_BITS+1)'(1) << ADC_BITS;

	logic [ADC_BITS-1:0] max_q;
	logic [ADC_BITS:0]   min_q;
	logic [LEVEL_W-1:0]  peak_q;
	logic [ADC_BITS-1:0] max_s1;
	logic [ADC_BITS-1:0] min_s1;
	logic                pend_s1;

	logic [ADC_BITS-1:0] new_max;
	logic [ADC_BITS:0]   new_min;
	logic [ADC_BITS-1:0] diff;
	logic [LEVEL_W-1:0]  level;
	logic [LEVEL_W-1:0]  new_peak;
	logic                take;

	assign in_ready = !pend_s1 && !q_full;
	assign take     = in_valid && in_ready;

	// both extremes see every sample
	assign new_max = (in_sample > max_q) ? in_sample : max_q;
	assign new_min = ({1'b0, in_sample} < min_q) ? {1'b0, in_sample} : min_q;

	assign diff     = max_s1 - min_s1;
	assign level    = LEVEL_W'(diff) * LEVEL_W'(LEVEL_GAIN);
	assign new_peak = (level > peak_q) ? level : peak_q;

	assign q_push  = pend_s1;
	assign q_level = level;
	assign q_peak  = new_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			min_q   <= MIN_EMPTY;
			peak_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= take && in_last;
			if (pend_s1) begin
				peak_q <= new_peak;
			end
			if (take) begin
				if (in_last) begin
					max_q <= '0;
					min_q <= MIN_EMPTY;
				end else begin
					max_q <= new_max;
					min_q <= new_min;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_last) begin
			max_s1 <= new_max;
			min_s1 <= new_min[ADC_BITS-1:0];   // never above the sample
		end
	end

endmodule

// ===== sv/ptpag_queue.sv =====
module ptpag_queue #(
	parameter int WIDTH = 2 * (ptpag_pkg::ADC_BITS_DEF + 3)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic [$clog2(ptpag_pkg::Q_DEPTH):0] count
);
	import ptpag_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH) + 1;

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign pop_data = mem_q[rptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/ptpag_back.sv =====
module ptpag_back #(
	parameter int ADC_BITS = ptpag_pkg::ADC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [ADC_BITS+2:0]            q_level,
	input  logic [ADC_BITS+2:0]            q_peak,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ptpag_pkg::BRIGHT_W-1:0] out_bright,
	output logic [ptpag_pkg::LEVEL_FW-1:0] out_level
);
	import ptpag_pkg::*;

	localparam int LEVEL_W = ADC_BITS + 3;
	localparam int NUM_W   = LEVEL_W + BRIGHT_W;
	localparam int CNT_W   = $clog2(BRIGHT_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_W-1:0]    rem_q;
	logic [NUM_W-1:0]    dvs_q;
	logic [BRIGHT_W-1:0] quo_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic                zero_q;
	logic                valid_q;
	logic [BRIGHT_W-1:0] bright_q;
	logic [LEVEL_FW-1:0] level_q;

	logic             ge;
	logic [NUM_W-1:0] lvl_wide;
	logic             load_out;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign ge       = (rem_q >= dvs_q);
	assign lvl_wide = NUM_W'(lvl_q);
	assign load_out = (state_q == ST_DONE) && (!valid_q || out_ready);

	assign out_valid  = valid_q;
	assign out_bright = bright_q;
	assign out_level  = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(BRIGHT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divide, one quotient bit per cycle; quotient fits 8 bits as level <= peak
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q  <= NUM_W'(q_level) * NUM_W'(FULL_SCALE);
			dvs_q  <= NUM_W'(q_peak) << (BRIGHT_W - 1);
			lvl_q  <= q_level;
			zero_q <= (q_peak == '0);
			quo_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[BRIGHT_W-2:0], ge};
		end
		if (load_out) begin
			bright_q <= zero_q ? '0 : quo_q;
			level_q  <= lvl_wide[LEVEL_FW-1:0];
		end
	end

endmodule

// ===== sv/peak_to_peak_auto_gain_level.sv =====
// Peak-to-peak sound level with automatic gain.
// Input stream: s_tdata carries one ADC sample, s_tlast marks the last sample of a
// measuring window. Samples that do not close a window are taken one per cycle
// while the queue has room. In the cycle after a window-closing sample the input
// drops tready while the front stage forms level = (max - min) * 5 and raises
// the running peak. Output stream: one transaction per window with brightness =
// level * 255 / peak (0 while the peak is still 0) and the level itself.
// The back end is an 8-step restoring divider, one quotient bit per cycle; a result
// passes the queue, the idle state, the divide steps and the done state before it
// shows on m_tvalid, and the next window is taken once it is in the output register.
// A two-entry queue sits between front and back; when the receiver stalls, the
// finished result holds in the output register, the divider keeps working on the
// next window, and the input stalls only once that queue is full.
// Reset clears the window extremes, the running peak, the queue and the output valid.
module peak_to_peak_auto_gain_level #(
	parameter int ADC_BITS = ptpag_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]       s_tdata,  // [ADC_BITS-1:0] sample
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ptpag_pkg::OUT_DATA_W-1:0]    m_tdata   // [7:0] brightness, [20:8] level
);
	import ptpag_pkg::*;

	localparam int LEVEL_W = ADC_BITS + 3;
	localparam int PAD_W   = OUT_DATA_W - BRIGHT_W - LEVEL_FW;

	logic                      q_push;
	logic                      q_pop;
	logic                      q_full;
	logic                      q_empty;
	logic [$clog2(Q_DEPTH):0]  q_count;
	logic [LEVEL_W-1:0]        push_level;
	logic [LEVEL_W-1:0]        push_peak;
	logic [2*LEVEL_W-1:0]      pop_data;
	logic [BRIGHT_W-1:0]       bright;
	logic [LEVEL_FW-1:0]       level;

	ptpag_front #(.ADC_BITS(ADC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_sample(s_tdata[ADC_BITS-1:0]),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_level  (push_level),
		.q_peak   (push_peak)
	);

	ptpag_queue #(.WIDTH(2 * LEVEL_W)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_peak, push_level}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.count    (q_count)
	);

	ptpag_back #(.ADC_BITS(ADC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_level   (pop_data[LEVEL_W-1:0]),
		.q_peak    (pop_data[2*LEVEL_W-1:LEVEL_W]),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bright(bright),
		.out_level (level)
	);

	assign m_tdata = {{PAD_W{1'b0}}, level, bright};

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after a window-closing sample");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(Q_DEPTH)+1)'(Q_DEPTH) && !(q_push && q_full))
		else $error("window queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("divider took from an empty queue");

	a_flat_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(ADC_BITS <= ADC_BITS_DEF) && m_tvalid && level == '0 |-> bright == '0)
		else $error("flat window gave nonzero brightness");

endmodule

// ===== tb/ptpag_level_checker.sv =====
module ptpag_level_checker #(
	parameter int ADC_BITS = ptpag_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]       s_tdata,  // [ADC_BITS-1:0] sample
	input  logic                                s_tlast,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [ptpag_pkg::OUT_DATA_W-1:0]    m_tdata,  // [7:0] brightness, [20:8] level
	output int                                  errors,
	output int                                  pending
);
	import ptpag_pkg::*;

	localparam int PAD_LO = BRIGHT_W + LEVEL_FW;

	typedef struct packed {
		logic [BRIGHT_W-1:0] brightness;
		logic [LEVEL_FW-1:0] level;
	} gain_result_t;

	gain_result_t        gain_q[$];
	logic [ADC_BITS-1:0] win_max;
	logic [ADC_BITS:0]   win_min;
	int unsigned         peak_level;
	int                  windows_seen;

	task automatic report_failure(input string msg);
		errors++;
		$display("%0t: window %0d: %s", $time, windows_seen, msg);
	endtask

	task automatic clear_window();
		win_max = '0;
		win_min = (ADC_BITS+1)'(1) << ADC_BITS;
	endtask

	// one accepted sample; a window-closing sample is counted before the level is formed
	task automatic absorb_sample(input logic [ADC_BITS-1:0] s, input logic closes);
		int unsigned  lvl;
		int unsigned  bright;
		gain_result_t r;
		if (s > win_max)
			win_max = s;
		if ({1'b0, s} < win_min)
			win_min = {1'b0, s};
		if (closes) begin
			lvl = (32'(win_max) - 32'(win_min)) * LEVEL_GAIN;
			if (lvl > peak_level)
				peak_level = lvl;
			bright = (peak_level != 0) ? (lvl * FULL_SCALE) / peak_level : 0;
			r.brightness = bright[BRIGHT_W-1:0];
			r.level = lvl[LEVEL_FW-1:0];
			gain_q.push_back(r);
			clear_window();
		end
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] d);
		gain_result_t want;
		logic [BRIGHT_W-1:0] got_bright;
		logic [LEVEL_FW-1:0] got_level;
		got_bright = d[BRIGHT_W-1:0];
		got_level = d[BRIGHT_W +: LEVEL_FW];
		if (gain_q.size() == 0) begin
			report_failure($sformatf("result with none pending: brightness %0d level %0d",
				got_bright, got_level));
		end else begin
			want = gain_q.pop_front();
			if (got_bright !== want.brightness)
				report_failure($sformatf("brightness %0d, want %0d", got_bright, want.brightness));
			if (got_level !== want.level)
				report_failure($sformatf("level %0d, want %0d", got_level, want.level));
			if (d[OUT_DATA_W-1:PAD_LO] !== '0)
				report_failure($sformatf("padding bits %b not zero", d[OUT_DATA_W-1:PAD_LO]));
		end
		windows_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			peak_level = 0;
			gain_q.delete();
			windows_seen = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				absorb_sample(s_tdata[ADC_BITS-1:0], s_tlast);
			pending = gain_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import ptpag_pkg::*;

	localparam int ADC_BITS     = ADC_BITS_DEF;
	localparam int IN_W         = ((ADC_BITS+7)/8)*8;
	localparam int SAMPLE_MAX   = (1 << ADC_BITS) - 1;
	localparam int RANDOM_ITEMS = 800;
	localparam int STALL_LIMIT  = 4000;  // idle cycles; longest legal gap is the long receiver hold
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 200;   // samples sent before the long receiver hold

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata  = '0;   // [ADC_BITS-1:0] sample
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [7:0] brightness, [20:8] level

	int errors;
	int pending;
	int samples_sent = 0;
	bit sender_calm = 0;
	bit receiver_calm = 0;
	bit hold_done = 0;

	peak_to_peak_auto_gain_level #(.ADC_BITS(ADC_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ptpag_level_checker #(.ADC_BITS(ADC_BITS)) level_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none at all while calm
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_sample(input int s, input logic closes);
		int gap;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(s & SAMPLE_MAX);
		s_tlast <= closes;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic send_window(input int len, input int base, input int span);
		int s;
		for (int i = 0; i < len; i++) begin
			s = base + $urandom_range(0, span);
			if (s > SAMPLE_MAX)
				s = SAMPLE_MAX;
			send_sample(s, i == len - 1);
		end
	endtask

	initial begin
		int r;
		int len;
		int span;
		int target;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero peak: flat and single-sample windows before any swing
		send_sample(0, 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample('h155, 1'b0);
		send_sample('h155, 1'b1);
		// full swing, both orders: min and max track independently
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(0, 1'b1);
		send_sample(0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample('h2AA, 1'b0);
		send_sample('h155, 1'b0);
		send_sample('h200, 1'b1);
		// single sample once the peak is set
		send_sample(700, 1'b1);
		send_sample(1, 1'b0);
		send_sample(2, 1'b1);
		send_sample(SAMPLE_MAX - 1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(512, 1'b1);

		target = samples_sent + RANDOM_ITEMS;
		while (samples_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				sender_calm = !sender_calm;
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 6);
			else if (r < 90)
				len = $urandom_range(7, 16);
			else
				len = $urandom_range(17, 40);
			r = $urandom_range(0, 99);
			if (r < 10)
				span = 0;
			else if (r < 50)
				span = $urandom_range(1, 63);
			else
				span = $urandom_range(64, SAMPLE_MAX);
			send_window(len, $urandom_range(0, SAMPLE_MAX), span);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("peak_to_peak_auto_gain_level verification clean");
		else
			$display("peak_to_peak_auto_gain_level verification failed");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			// long hold so the internal queue fills and the input stalls
			if (!hold_done && samples_sent >= HOLD_AFTER) begin
				hold_done = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 49) == 0)
				receiver_calm = !receiver_calm;
			gap = pick_gap(receiver_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("peak_to_peak_auto_gain_level verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ptpag_pkg.sv
sv/ptpag_front.sv
sv/ptpag_queue.sv
sv/ptpag_back.sv
sv/peak_to_peak_auto_gain_level.sv
tb/ptpag_level_checker.sv
tb/tb.sv
